@@ rtl/core/hall_sector_speed_estimator_top_defines.svh @@
// assertion macros for the files that check the block
`ifndef HALL_SECTOR_SPEED_ESTIMATOR_TOP_DEFINES_SVH
`define HALL_SECTOR_SPEED_ESTIMATOR_TOP_DEFINES_SVH

// checked at every edge, reset included
`define HSSE_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// checked only while out of reset
`define HSSE_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ rtl/core/hsse_pkg.sv @@
`timescale 1ns / 1ps

package hsse_pkg;

    // capture width and operand width of the shared multiplier
    localparam int CAPTURE_BITS       = 32;
    localparam int CAPTURE_FIELD_BITS = 32;
    localparam int MUL_BITS           = 32;
    localparam int WEIGHT_BITS        = MUL_BITS + 3;
    localparam int SUM_BITS           = 2 * MUL_BITS + 2;
    localparam int PROD_BITS          = 63;
    localparam int DEN_BITS           = SUM_BITS + 3;
    localparam int QUO_BITS           = 32;

    // register widths
    localparam int CLK_BITS    = 28;
    localparam int MAXSP_BITS  = 31;
    localparam int MINSQ_BITS  = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 64;

    // stream widths
    localparam int IN_USER_BITS  = 2;
    localparam int IN_DATA_BITS  = 3 * CAPTURE_FIELD_BITS;
    localparam int OUT_DATA_BITS = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMER_CLOCK = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SQUARE  = 2'd2;

    localparam logic [CLK_BITS-1:0]   RESET_TIMER_CLOCK = 28'd84000000;
    localparam logic [MAXSP_BITS-1:0] RESET_MAX_SPEED   = 31'd13107200;
    localparam logic [MINSQ_BITS-1:0] RESET_MIN_SQUARE  = 64'd141120000000;

    typedef enum logic [1:0] {
        CMD_EDGE_A = 2'd0,
        CMD_EDGE_B = 2'd1,
        CMD_EDGE_C = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_A = 2'd0;
    localparam sector_t SECTOR_C = 2'd2;

    typedef struct packed {
        logic [CLK_BITS-1:0]   timer_clock_hz;
        logic [MAXSP_BITS-1:0] max_speed;
        logic [MINSQ_BITS-1:0] min_square_sum;
    } cfg_t;

    // one classified request on its way to the back end
    typedef struct packed {
        cmd_t                    cmd;
        logic                    dir;
        sector_t                 sector;
        logic [CAPTURE_BITS-1:0] c1;
        logic [CAPTURE_BITS-1:0] c2;
        logic [CAPTURE_BITS-1:0] c3;
    } job_t;

endpackage

@@ rtl/core/hsse_front.sv @@
`timescale 1ns / 1ps

module hsse_front
    import hsse_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_USER_BITS-1:0] s_tuser,
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    output logic                    push_valid,
    input  logic                    push_ready,
    output job_t                    push_job
);

    sector_t sector_reg, sector_next;
    logic    dir_reg, dir_next;
    cmd_t    cmd;
    sector_t prev;
    logic [CAPTURE_BITS-1:0] cap_a, cap_b, cap_c;

    assign cmd   = cmd_t'(s_tuser);
    assign cap_a = s_tdata[CAPTURE_BITS-1:0];
    assign cap_b = s_tdata[CAPTURE_FIELD_BITS+CAPTURE_BITS-1:CAPTURE_FIELD_BITS];
    assign cap_c = s_tdata[2*CAPTURE_FIELD_BITS+CAPTURE_BITS-1:2*CAPTURE_FIELD_BITS];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // cyclic predecessor of the sector being entered
    assign prev = (cmd == CMD_EDGE_A) ? SECTOR_C : sector_t'(s_tuser - 2'd1);

    always_comb begin
        sector_next = sector_reg;
        dir_next    = dir_reg;
        if (cmd != CMD_CLEAR) begin
            dir_next    = (sector_reg != prev);
            sector_next = sector_t'(s_tuser);
        end
        push_job.cmd    = cmd;
        push_job.dir    = dir_next;
        push_job.sector = sector_next;
        // reverse swaps the first two counts
        push_job.c1     = dir_next ? cap_b : cap_a;
        push_job.c2     = dir_next ? cap_a : cap_b;
        push_job.c3     = cap_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg <= SECTOR_A;
            dir_reg    <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            sector_reg <= sector_next;
            dir_reg    <= dir_next;
        end
    end

endmodule

@@ rtl/core/hsse_queue.sv @@
`timescale 1ns / 1ps

module hsse_queue
    import hsse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : QPTR_BITS'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : QPTR_BITS'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                count_reg <= QCNT_BITS'(count_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                count_reg <= QCNT_BITS'(count_reg - 1'b1);
            end
        end
    end

endmodule

@@ rtl/core/hsse_back.sv @@
`timescale 1ns / 1ps

module hsse_back
    import hsse_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  job_t                     job,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_CHECK,
        ST_DIV
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             step_reg, step_next;
    logic [MUL_BITS-1:0]    c1_reg, c1_next, c2_reg, c2_next, c3_reg, c3_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [2*MUL_BITS-1:0]  prod_reg, prod_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [PROD_BITS-1:0]   pacc_reg, pacc_next;
    logic [DEN_BITS-1:0]    den_reg, den_next, rem_reg, rem_next;
    logic [QUO_BITS-1:0]    low_reg, low_next, quo_reg, quo_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic                   jdir_reg, jdir_next;
    sector_t                jsec_reg, jsec_next;
    logic [31:0]            speed_reg, speed_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_speed_reg, out_speed_next;
    logic                   out_dir_reg, out_dir_next;
    sector_t                out_sec_reg, out_sec_next;

    logic [MUL_BITS-1:0]    mul_a, mul_b;
    logic [2*MUL_BITS-1:0]  mul_prod;
    logic [DEN_BITS:0]      trial;
    logic [QUO_BITS-1:0]    quo_new;
    logic                   fin;
    logic [31:0]            fin_mag, fin_speed, max32;

    assign max32     = {1'b0, cfg.max_speed};
    assign job_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_sec_reg, out_dir_reg, out_speed_reg};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            3'd0: begin mul_a = c1_reg; mul_b = c1_reg; end
            3'd1: begin mul_a = c2_reg; mul_b = c2_reg; end
            3'd2: begin mul_a = c3_reg; mul_b = c3_reg; end
            3'd3: begin
                mul_a = MUL_BITS'(cfg.timer_clock_hz);
                mul_b = w_reg[MUL_BITS-1:0];
            end
            3'd4: begin
                mul_a = MUL_BITS'(cfg.timer_clock_hz);
                mul_b = MUL_BITS'(w_reg[WEIGHT_BITS-1:MUL_BITS]);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        c3_next        = c3_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        pacc_next      = pacc_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        jdir_next      = jdir_reg;
        jsec_next      = jsec_reg;
        speed_next     = speed_reg;
        out_valid_next = out_valid_reg;
        out_speed_next = out_speed_reg;
        out_dir_next   = out_dir_reg;
        out_sec_next   = out_sec_reg;
        trial          = '0;
        quo_new        = quo_reg;
        fin            = 1'b0;
        fin_mag        = '0;
        fin_speed      = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid && job_ready) begin
                    jdir_next = job.dir;
                    jsec_next = job.sector;
                    unique case (job.cmd)
                        CMD_EDGE_A: begin
                            c1_next   = MUL_BITS'(job.c1);
                            c2_next   = MUL_BITS'(job.c2);
                            c3_next   = MUL_BITS'(job.c3);
                            w_next    = WEIGHT_BITS'(job.c1)
                                      + (WEIGHT_BITS'(job.c2) << 1)
                                      + (WEIGHT_BITS'(job.c3) << 1)
                                      + WEIGHT_BITS'(job.c3);
                            step_next  = 3'd0;
                            state_next = ST_MUL;
                        end
                        CMD_CLEAR: begin
                            speed_next     = '0;
                            out_speed_next = '0;
                            out_dir_next   = job.dir;
                            out_sec_next   = job.sector;
                            out_valid_next = 1'b1;
                        end
                        default: begin
                            // edges on B or C keep the speed
                            out_speed_next = speed_reg;
                            out_dir_next   = job.dir;
                            out_sec_next   = job.sector;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                prod_next = mul_prod;
                step_next = 3'(step_reg + 1'b1);
                case (step_reg)
                    3'd1: sum_next = SUM_BITS'(prod_reg);
                    3'd2, 3'd3: sum_next = sum_reg + SUM_BITS'(prod_reg);
                    3'd4: pacc_next = prod_reg[PROD_BITS-1:0];
                    3'd5: begin
                        pacc_next  = pacc_reg + {prod_reg[PROD_BITS-MUL_BITS-1:0],
                                                 {MUL_BITS{1'b0}}};
                        state_next = ST_PREP;
                    end
                    default: ;
                endcase
            end
            ST_PREP: begin
                // six times the square sum
                den_next = {2'b00, sum_reg, 1'b0} + {1'b0, sum_reg, 2'b00};
                if (sum_reg[SUM_BITS-1:MINSQ_BITS] == '0 &&
                    sum_reg[MINSQ_BITS-1:0] <= cfg.min_square_sum) begin
                    fin     = 1'b1;
                    fin_mag = max32;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // quotient of 2^32 or more saturates
                if (DEN_BITS'(pacc_reg[PROD_BITS-1:16]) >= den_reg) begin
                    fin     = 1'b1;
                    fin_mag = max32;
                end else begin
                    rem_next   = DEN_BITS'(pacc_reg[PROD_BITS-1:16]);
                    low_next   = {pacc_reg[15:0], 16'd0};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                trial = {rem_reg, low_reg[QUO_BITS-1]};
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = DEN_BITS'(trial - {1'b0, den_reg});
                    quo_new  = {quo_reg[QUO_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial[DEN_BITS-1:0];
                    quo_new  = {quo_reg[QUO_BITS-2:0], 1'b0};
                end
                quo_next = quo_new;
                low_next = {low_reg[QUO_BITS-2:0], 1'b0};
                cnt_next = 5'(cnt_reg + 1'b1);
                if (cnt_reg == 5'd31) begin
                    fin     = 1'b1;
                    fin_mag = (quo_new > max32) ? max32 : quo_new;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (fin) begin
            fin_speed      = jdir_reg ? 32'(32'd0 - fin_mag) : fin_mag;
            speed_next     = fin_speed;
            out_speed_next = fin_speed;
            out_dir_next   = jdir_reg;
            out_sec_next   = jsec_reg;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        c3_reg        <= c3_next;
        w_reg         <= w_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        pacc_reg      <= pacc_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        quo_reg       <= quo_next;
        jdir_reg      <= jdir_next;
        jsec_reg      <= jsec_next;
        out_speed_reg <= out_speed_next;
        out_dir_reg   <= out_dir_next;
        out_sec_reg   <= out_sec_next;
    end

endmodule

@@ rtl/core/hall_sector_speed_estimator_top.sv @@
// hall sector speed estimator
// s_ channel: one request per hall event; s_tuser carries the command
//   (edge on sensor a, b or c, or clear speed), s_tdata the three captured
//   timer counts. m_ channel: one result per request with the signed q16.16
//   speed, the direction and the current sector.
// cfg_ port: plain register writes; write only while the block is idle (not enforced by the block).
// the front end classifies each request at once (sector, direction, count
//   swap) and drops it into a two-entry queue; the back end drains it.
// edges on b or c and clear commands are answered from the idle state straight
//   into the output register; an edge on a runs six steps on the
//   one 32x32 multiplier, two set-up states and a 32-step restoring divider,
//   shorter when the speed saturates early.
// throughput: the back end takes no new request until an a edge is done;
//   other requests one per cycle while the receiver takes results.
// reset clears sector, direction and speed to zero and loads the default
//   registers; a stalled receiver holds the output register, the queue then
//   fills and s_tready drops.
`timescale 1ns / 1ps
`include "hall_sector_speed_estimator_top_defines.svh"

module hall_sector_speed_estimator_top
    import hsse_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // fields from bit 0: command
    input  logic [IN_USER_BITS-1:0]  s_tuser,
    // fields from bit 0: capture_a, capture_b, capture_c
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // fields from bit 0: speed_q16, direction, sector, zero fill
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic push_valid, push_ready;
    job_t push_job;
    logic q_pop_valid, q_pop_ready;
    job_t pop_job;

    // configuration registers, writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timer_clock_hz <= RESET_TIMER_CLOCK;
            cfg_reg.max_speed      <= RESET_MAX_SPEED;
            cfg_reg.min_square_sum <= RESET_MIN_SQUARE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIMER_CLOCK: cfg_reg.timer_clock_hz <= cfg_wdata[CLK_BITS-1:0];
                REG_MAX_SPEED:   cfg_reg.max_speed      <= cfg_wdata[MAXSP_BITS-1:0];
                REG_MIN_SQUARE:  cfg_reg.min_square_sum <= cfg_wdata[MINSQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    // front end: sector and direction tracking
    hsse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // short queue between the two halves
    hsse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_job    (pop_job)
    );

    // back end: speed arithmetic and output register
    hsse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (q_pop_valid),
        .job_ready (q_pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // output register empties on reset
    `HSSE_ASSERT_CLK(a_reset_empties_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // sector code stays within the three sectors
    `HSSE_ASSERT_RST(a_sector_range, aclk, aresetn, m_tvalid |-> (m_tdata[34:33] != 2'd3), "bad sector")

    // back end never takes a request while a result is stalled
    `HSSE_ASSERT_RST(a_no_pop_when_stalled, aclk, aresetn, (q_pop_valid && q_pop_ready) |-> !(m_tvalid && !m_tready), "pop while stalled")

endmodule

@@ verif/tb_hall_sector_speed_estimator_top.sv @@
`timescale 1ns / 1ps

module tb_hall_sector_speed_estimator_top;
    import hsse_pkg::*;

    localparam int  HALF_PERIOD_NS   = 5;
    localparam int  RESET_CYCLES     = 4;
    localparam int  RANDOM_PHASES    = 6;
    localparam int  ITEMS_PER_PHASE  = 142;
    localparam int  MAX_IDLE         = 12;
    // one long receiver hold-off, long enough to fill the queue and stall s_tready
    localparam int  HOLD_AT_READING  = 300;
    localparam int  HOLD_CYCLES      = 600;
    // long enough to cover the slowest request, an edge on sensor a
    localparam int  DRAIN_CYCLES     = 60;
    // many times the slowest correct run
    localparam longint TIMEOUT_NS    = 64'd10_000_000;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    // one result as the block reports it
    typedef struct packed {
        logic [31:0] speed;
        logic        reverse;
        sector_t     sector;
    } reading_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_WRITE
    } row_kind_t;

    // one line of the directed table: a request or a register write
    typedef struct {
        row_kind_t               kind;
        cmd_t                    cmd;
        logic [31:0]             ca;
        logic [31:0]             cb;
        logic [31:0]             cc;
        logic                    typed;
        reading_t                want;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [63:0]             value;
    } row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic [IN_USER_BITS-1:0]  s_tuser   = '0;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic [CLK_BITS-1:0]   cfg_timer_clock = RESET_TIMER_CLOCK;
    logic [MAXSP_BITS-1:0] cfg_max_speed   = RESET_MAX_SPEED;
    logic [MINSQ_BITS-1:0] cfg_min_square  = RESET_MIN_SQUARE;

    // predictor copy of the rotor state
    sector_t     rotor_sector  = SECTOR_A;
    logic        rotor_reverse = 1'b0;
    logic [31:0] rotor_speed   = '0;

    reading_t pending_readings[$];
    row_t     stimulus_table[$];
    int       mismatch_count = 0;
    int       readings_seen  = 0;
    logic     send_burst     = 1'b0;
    logic     take_burst     = 1'b0;

    always #HALF_PERIOD_NS aclk = ~aclk;

    hall_sector_speed_estimator_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),   // fields from bit 0: command
        .s_tdata   (s_tdata),   // fields from bit 0: capture_a, capture_b, capture_c
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // fields from bit 0: speed_q16, direction, sector, zero fill
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // exact floor(clk * w * 2^16 / (6 * s)), saturated to max_speed
    function automatic logic [31:0] rotor_speed_magnitude(input logic [31:0] c1,
                                                          input logic [31:0] c2,
                                                          input logic [31:0] c3);
        logic [127:0] x1, x2, x3, sq_sum, numer, denom, quot;
        x1 = c1;
        x2 = c2;
        x3 = c3;
        sq_sum = x1 * x1 + x2 * x2 + x3 * x3;
        // too short a period (or all counts zero) reads as top speed
        if (sq_sum <= {64'd0, cfg_min_square})
            return {1'b0, cfg_max_speed};
        numer = ({100'd0, cfg_timer_clock} * (x1 + 2 * x2 + 3 * x3)) << 16;
        denom = 6 * sq_sum;
        quot  = numer / denom;
        if (quot > {97'd0, cfg_max_speed})
            return {1'b0, cfg_max_speed};
        return quot[31:0];
    endfunction

    // moves the rotor state on by one request and returns the reading it gives
    function automatic reading_t predict_reading(input cmd_t cmd, input logic [31:0] ca,
                                                 input logic [31:0] cb, input logic [31:0] cc);
        sector_t     prev;
        logic [31:0] mag;
        if (cmd == CMD_CLEAR) begin
            rotor_speed = '0;
        end else begin
            // forward only when we come from the cyclic predecessor
            prev = (cmd == CMD_EDGE_A) ? SECTOR_C : sector_t'(cmd) - 2'd1;
            rotor_reverse = (rotor_sector != prev);
            rotor_sector  = sector_t'(cmd);
            if (cmd == CMD_EDGE_A) begin
                // reverse rotation swaps the first two counts
                mag = rotor_reverse ? rotor_speed_magnitude(cb, ca, cc)
                                    : rotor_speed_magnitude(ca, cb, cc);
                rotor_speed = rotor_reverse ? 32'd0 - mag : mag;
            end
        end
        return '{speed: rotor_speed, reverse: rotor_reverse, sector: rotor_sector};
    endfunction

    function automatic void add_request(input cmd_t cmd, input logic [31:0] ca,
                                        input logic [31:0] cb, input logic [31:0] cc);
        row_t row;
        row = '{kind: ROW_REQUEST, cmd: cmd, ca: ca, cb: cb, cc: cc, typed: 1'b0,
                want: '0, idx: '0, value: '0};
        stimulus_table.push_back(row);
    endfunction

    function automatic void add_typed(input cmd_t cmd, input logic [31:0] ca,
                                      input logic [31:0] cb, input logic [31:0] cc,
                                      input logic [31:0] speed, input logic reverse,
                                      input sector_t sector);
        row_t row;
        row = '{kind: ROW_REQUEST, cmd: cmd, ca: ca, cb: cb, cc: cc, typed: 1'b1,
                want: '{speed: speed, reverse: reverse, sector: sector},
                idx: '0, value: '0};
        stimulus_table.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [63:0] value);
        row_t row;
        row = '{kind: ROW_WRITE, cmd: CMD_CLEAR, ca: '0, cb: '0, cc: '0, typed: 1'b0,
                want: '0, idx: idx, value: value};
        stimulus_table.push_back(row);
    endfunction

    // drops s_tvalid and waits until every reading has come back
    task automatic wait_idle();
        if (pending_readings.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_readings.size() != 0)
                @(posedge aclk);
        end
    endtask

    // only called while the block is idle
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [63:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_TIMER_CLOCK: cfg_timer_clock = value[CLK_BITS-1:0];
            REG_MAX_SPEED:   cfg_max_speed   = value[MAXSP_BITS-1:0];
            REG_MIN_SQUARE:  cfg_min_square  = value[MINSQ_BITS-1:0];
            default: ;
        endcase
    endtask

    // offers one request after a random gap and books its reading once accepted
    task automatic send_request(input cmd_t cmd, input logic [31:0] ca,
                                input logic [31:0] cb, input logic [31:0] cc,
                                input logic typed, input reading_t want);
        int       gap;
        reading_t predicted;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        cfg_wr_en <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {cc, cb, ca};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = predict_reading(cmd, ca, cb, cc);
        // typed rows keep the predictor in step but check the value read off by hand
        pending_readings.push_back(typed ? want : predicted);
    endtask

    // result side: random stalls, one long hold-off, field by field check
    initial begin
        int       stall;
        reading_t got;
        reading_t want;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            if (readings_seen == HOLD_AT_READING)
                stall = HOLD_CYCLES;
            else
                stall = take_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            readings_seen++;
            got = '{speed: m_tdata[31:0], reverse: m_tdata[32], sector: m_tdata[34:33]};
            if (pending_readings.size() == 0) begin
                $error("unexpected result: speed_q16 %0d", $signed(got.speed));
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (got.speed !== want.speed) begin
                    $error("speed_q16: expected %0d, got %0d",
                           $signed(want.speed), $signed(got.speed));
                    mismatch_count++;
                end
                if (got.reverse !== want.reverse) begin
                    $error("direction: expected %0d, got %0d", want.reverse, got.reverse);
                    mismatch_count++;
                end
                if (got.sector !== want.sector) begin
                    $error("sector: expected %0d, got %0d", want.sector, got.sector);
                    mismatch_count++;
                end
            end
        end
    end

    // hard limit on the whole run
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        row_t        row;
        cmd_t        cmd;
        sector_t     next_sector;
        logic        spin_back;
        logic [31:0] ca, cb, cc, mask;
        logic [63:0] min_value;
        int          width;
        int          roll;

        // directed part, reset register values first
        add_typed(CMD_CLEAR, '0, '0, '0, 32'd0, 1'b0, 2'd0);
        // captures sent with b and c commands are ignored
        add_typed(CMD_EDGE_B, '1, '1, '1, 32'd0, 1'b0, 2'd1);
        add_typed(CMD_EDGE_C, '1, '1, '1, 32'd0, 1'b0, 2'd2);
        // all counts zero saturates, forward then reverse
        add_typed(CMD_EDGE_A, '0, '0, '0, 32'd13107200, 1'b0, 2'd0);
        add_typed(CMD_EDGE_A, '0, '0, '0, -32'sd13107200, 1'b1, 2'd0);
        add_request(CMD_EDGE_A, '1, '1, '1);
        add_typed(CMD_CLEAR, '1, '1, '1, 32'd0, 1'b1, 2'd0);
        // backwards through c and b
        add_typed(CMD_EDGE_C, '0, '0, '0, 32'd0, 1'b1, 2'd2);
        add_typed(CMD_EDGE_B, '0, '0, '0, 32'd0, 1'b1, 2'd1);
        add_request(CMD_EDGE_A, 32'd1_000_000, 32'd900_000, 32'd3_000_000);
        // speed holds across b and c commands
        add_request(CMD_EDGE_B, 32'd5, 32'd6, 32'd7);
        add_request(CMD_EDGE_C, 32'd5, 32'd6, 32'd7);
        add_request(CMD_EDGE_A, 32'd1_000_000, 32'd900_000, 32'd3_000_000);
        add_request(CMD_EDGE_A, '0, '0, 32'h8000_0000);
        // threshold right at the sum of squares, then one above
        add_write(REG_MIN_SQUARE, 64'd100);
        add_write(REG_MAX_SPEED, 64'h7FFF_FFFF);
        add_write(REG_TIMER_CLOCK, 64'd1);
        add_request(CMD_EDGE_B, '0, '0, '0);
        add_request(CMD_EDGE_C, '0, '0, '0);
        add_typed(CMD_EDGE_A, 32'd0, 32'd0, 32'd10, 32'h7FFF_FFFF, 1'b0, 2'd0);
        add_request(CMD_EDGE_B, '0, '0, '0);
        add_request(CMD_EDGE_C, '0, '0, '0);
        add_request(CMD_EDGE_A, 32'd1, 32'd0, 32'd10);
        // wide write is cut to the register width, unused index does nothing
        add_write(REG_TIMER_CLOCK, '1);
        add_write(REG_UNUSED, '1);
        add_typed(CMD_EDGE_A, 32'd0, 32'd0, 32'd11, 32'h8000_0001, 1'b1, 2'd0);
        add_write(REG_MAX_SPEED, 64'd0);
        add_typed(CMD_EDGE_A, '0, '0, '0, 32'd0, 1'b1, 2'd0);
        // zero timer clock gives zero unless saturated
        add_write(REG_TIMER_CLOCK, 64'd0);
        add_write(REG_MAX_SPEED, 64'd13107200);
        add_typed(CMD_EDGE_A, 32'd5, 32'd7, 32'd9, 32'd0, 1'b1, 2'd0);
        add_write(REG_MIN_SQUARE, '1);
        add_typed(CMD_EDGE_A, '1, '0, '0, -32'sd13107200, 1'b1, 2'd0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stimulus_table[i]) begin
            row = stimulus_table[i];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_register(row.idx, row.value);
            end else begin
                send_request(row.cmd, row.ca, row.cb, row.cc, row.typed, row.want);
            end
        end

        // random part, a fresh register setting per phase
        spin_back = 1'b0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_register(REG_TIMER_CLOCK, 64'(RESET_TIMER_CLOCK));
                    write_register(REG_MAX_SPEED, 64'(RESET_MAX_SPEED));
                    write_register(REG_MIN_SQUARE, RESET_MIN_SQUARE);
                end
                1: begin
                    // top of timer clock and max speed, no low-speed threshold
                    write_register(REG_TIMER_CLOCK, '1);
                    write_register(REG_MAX_SPEED, 64'h7FFF_FFFF);
                    write_register(REG_MIN_SQUARE, 64'd0);
                end
                2: begin
                    // slowest clock, speeds near zero
                    write_register(REG_TIMER_CLOCK, 64'd1);
                    write_register(REG_MAX_SPEED, 64'($urandom_range(0, 32'h7FFF_FFFF)));
                    write_register(REG_MIN_SQUARE, 64'd0);
                end
                default: begin
                    write_register(REG_TIMER_CLOCK, 64'($urandom_range(1, 200_000_000)));
                    write_register(REG_MAX_SPEED, 64'($urandom_range(0, 32'h7FFF_FFFF)));
                    min_value = {$urandom, $urandom} >> $urandom_range(24, 63);
                    write_register(REG_MIN_SQUARE, min_value);
                    write_register(REG_UNUSED, {$urandom, $urandom});
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // once let everything drain mid-phase before going on
                if (phase == 1 && n == 70)
                    wait_idle();

                // mostly a clean rotation, now and then a reversal, clears and noise
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    cmd = CMD_CLEAR;
                end else if (roll < 25) begin
                    cmd = cmd_t'($urandom_range(0, 2));
                end else begin
                    if ($urandom_range(0, 29) == 0)
                        spin_back = !spin_back;
                    if (spin_back)
                        next_sector = (rotor_sector == SECTOR_A) ? SECTOR_C
                                                                 : rotor_sector - 2'd1;
                    else
                        next_sector = (rotor_sector == SECTOR_C) ? SECTOR_A
                                                                 : rotor_sector + 2'd1;
                    cmd = cmd_t'(next_sector);
                end

                // counts mostly of a realistic size so the divider does real work
                width = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32)
                                                    : $urandom_range(18, 32);
                mask = (width == 32) ? '1 : (32'd1 << width) - 32'd1;
                ca = $urandom & mask;
                cb = $urandom & mask;
                cc = $urandom & mask;
                send_request(cmd, ca, cb, cc, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ hall_sector_speed_estimator_top.f @@
+incdir+rtl/core
rtl/core/hsse_pkg.sv
rtl/core/hsse_front.sv
rtl/core/hsse_queue.sv
rtl/core/hsse_back.sv
rtl/core/hall_sector_speed_estimator_top.sv
verif/tb_hall_sector_speed_estimator_top.sv
